// ===== src/mpfd_pkg.sv =====
// Package for the meter packet framer and decoder.
// Holds the packet length, character codes, decode codes and shared types.
// No dependencies.
package mpfd_pkg;

  // Packet length in bytes, including the trailing CR LF (11 to 16).
  localparam int unsigned PacketLength = 11;
  // Number of byte cells: every packet byte before the closing LF.
  localparam int unsigned NumCells     = PacketLength - 1;
  // Bytes of the packet that the decoder looks at.
  localparam int unsigned NumDecBytes  = 9;
  localparam int unsigned CountWidth   = 4;

  // Character codes.
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharLess  = 8'h3c;
  localparam logic [7:0] CharZero  = 8'h30;

  localparam logic [3:0] NibbleMask = 4'hf;
  localparam int unsigned SignBit   = 2;

  // Function codes.
  localparam logic [3:0] FnAcMilliV  = 4'd0;
  localparam logic [3:0] FnDcV       = 4'd1;
  localparam logic [3:0] FnAcV       = 4'd2;
  localparam logic [3:0] FnDcMilliV  = 4'd3;
  localparam logic [3:0] FnOhm       = 4'd4;
  localparam logic [3:0] FnCap       = 4'd5;
  localparam logic [3:0] FnTempC     = 4'd6;
  localparam logic [3:0] FnMicroA    = 4'd7;
  localparam logic [3:0] FnMilliA    = 4'd8;
  localparam logic [3:0] FnAmp       = 4'd9;
  localparam logic [3:0] FnCont      = 4'd10;
  localparam logic [3:0] FnDiode     = 4'd11;
  localparam logic [3:0] FnFreq      = 4'd12;
  localparam logic [3:0] FnTempF     = 4'd13;

  // Prefix codes.
  localparam logic [2:0] PreNone  = 3'd0;
  localparam logic [2:0] PreMilli = 3'd1;
  localparam logic [2:0] PreKilo  = 3'd2;
  localparam logic [2:0] PreMega  = 3'd3;
  localparam logic [2:0] PreNano  = 3'd4;
  localparam logic [2:0] PreMicro = 3'd5;

  // Unit codes.
  localparam logic [2:0] UnitVolt    = 3'd0;
  localparam logic [2:0] UnitOhm     = 3'd1;
  localparam logic [2:0] UnitFarad   = 3'd2;
  localparam logic [2:0] UnitDegC    = 3'd3;
  localparam logic [2:0] UnitAmp     = 3'd4;
  localparam logic [2:0] UnitHertz   = 3'd5;
  localparam logic [2:0] UnitPercent = 3'd6;
  localparam logic [2:0] UnitDegF    = 3'd7;

  // Mode codes.
  localparam logic [3:0] ModeAc    = 4'd0;
  localparam logic [3:0] ModeDc    = 4'd1;
  localparam logic [3:0] ModeAcDc  = 4'd2;
  localparam logic [3:0] ModeOhm   = 4'd3;
  localparam logic [3:0] ModeCap   = 4'd4;
  localparam logic [3:0] ModeTemp  = 4'd5;
  localparam logic [3:0] ModeDiode = 4'd6;
  localparam logic [3:0] ModeDuty  = 4'd7;
  localparam logic [3:0] ModeFreq  = 4'd8;

  // The packet bytes that the decoder reads, byte 0 first.
  typedef logic [NumDecBytes-1:0][7:0] packet_t;

  // One result item.
  typedef struct packed {
    logic        has_value;
    logic [39:0] digit_bytes;
    logic        five_digits;
    logic        negative;
    logic        point_valid;
    logic [3:0]  point_position;
    logic [2:0]  prefix_code;
    logic [2:0]  unit_code;
    logic [3:0]  mode_code;
    logic        overflow;
    logic [3:0]  function_code;
    logic [3:0]  range_code;
  } result_t;

  // Mode for the current functions: AC, DC or AC+DC from the coupling byte.
  function automatic logic [3:0] ac_dc_mode(input logic [7:0] b);
    logic [3:0] m;
    if (b[0]) begin
      m = b[1] ? ModeAcDc : ModeAc;
    end else begin
      m = ModeDc;
    end
    return m;
  endfunction

endpackage

// ===== src/meter_packet_framer_decoder.sv =====
// Top level of the meter packet framer and decoder.
// Uses mpfd_pkg, mpfd_cell (byte shift line) and mpfd_decode.
//
//   channel   dir  payload
//   s_axis    in   tdata: rx_byte; tuser: port_error
//   m_axis    out  tdata: decoded fields; tuser: has_value
//
// One item is accepted per cycle; a result, when the item closes a packet,
// appears in the output register on the next cycle. The decode table reads the
// cell row in the same cycle as the closing byte arrives. Input is stalled only
// while a result waits and the output side is not ready. Reset clears the
// byte count, the stored mode and unit and the output valid flag.
module meter_packet_framer_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] port_error
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [39:0] digit_bytes, [40] five_digits, [41] negative, [42] point_valid,
  // [46:43] point_position, [49:47] prefix_code, [52:50] unit_code,
  // [56:53] mode_code, [57] overflow, [61:58] function_code,
  // [65:62] range_code, [71:66] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] has_value
);

  localparam logic [mpfd_pkg::CountWidth-1:0] LastCount =
    mpfd_pkg::CountWidth'(mpfd_pkg::PacketLength - 1);

  logic                               accept, shift, is_lf, at_last, emit, good;
  logic [mpfd_pkg::CountWidth-1:0]    count_q, count_d;
  logic [7:0]                         cell_in [mpfd_pkg::NumCells];
  logic [7:0]                         cell_out [mpfd_pkg::NumCells];
  mpfd_pkg::packet_t                  pkt;
  mpfd_pkg::result_t                  dec_res, res_q, res_d;
  logic                               out_valid_q, out_valid_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign shift         = accept && !s_axis_tuser;

  // Row of byte cells; cell 0 holds the most recent earlier byte.
  for (genvar g = 0; g < mpfd_pkg::NumCells; g++) begin : g_cells
    if (g == 0) begin : g_head
      assign cell_in[g] = s_axis_tdata;
    end else begin : g_link
      assign cell_in[g] = cell_out[g-1];
    end
    mpfd_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .byte_i (cell_in[g]),
      .byte_o (cell_out[g])
    );
  end

  // Packet byte k sits in cell PacketLength-2-k when the closing LF arrives.
  for (genvar k = 0; k < mpfd_pkg::NumDecBytes; k++) begin : g_pkt
    assign pkt[k] = cell_out[mpfd_pkg::PacketLength-2-k];
  end

  // Framing: count bytes and check the CR LF tail.
  assign is_lf   = (s_axis_tdata == mpfd_pkg::CharLf);
  assign at_last = (count_q == LastCount);
  assign emit    = s_axis_tuser || is_lf || at_last;
  assign good    = !s_axis_tuser && is_lf && at_last && (cell_out[0] == mpfd_pkg::CharCr);
  assign count_d = emit ? '0 : count_q + 1'b1;

  mpfd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pkt_i   (pkt),
    .update_i(accept && good),
    .res_o   (dec_res)
  );

  // Output register selection.
  always_comb begin
    res_d       = good ? dec_res : '0;
    out_valid_d = out_valid_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.has_value;
  assign m_axis_tdata  = {6'd0, res_q.range_code, res_q.function_code, res_q.overflow,
                          res_q.mode_code, res_q.unit_code, res_q.prefix_code,
                          res_q.point_position, res_q.point_valid, res_q.negative,
                          res_q.five_digits, res_q.digit_bytes};

endmodule

// ===== src/mpfd_cell.sv =====
// One byte cell of the packet shift line.
// Takes the byte of its upstream neighbor on each shift. No other dependencies.
module mpfd_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;

  // Payload register, so no reset.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== src/mpfd_decode.sv =====
// Packet decoder: turns the framed bytes into a result item.
// Keeps the last mode and unit for unknown functions. Depends on mpfd_pkg.
module mpfd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpfd_pkg::packet_t pkt_i,
  input  logic              update_i,
  output mpfd_pkg::result_t res_o
);

  logic [3:0] last_mode_q, last_mode_d;
  logic [2:0] last_unit_q, last_unit_d;
  logic [3:0] fn, rg;
  logic       pv;
  logic [3:0] pp;
  logic [2:0] pre;

  assign fn = pkt_i[6][3:0] & mpfd_pkg::NibbleMask;
  assign rg = pkt_i[5][3:0] & mpfd_pkg::NibbleMask;

  // Function and range table.
  always_comb begin
    pv          = 1'b0;
    pp          = 4'd0;
    pre         = mpfd_pkg::PreNone;
    last_mode_d = last_mode_q;
    last_unit_d = last_unit_q;
    case (fn)
      mpfd_pkg::FnAcMilliV: begin
        pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreMilli;
        last_mode_d = mpfd_pkg::ModeAc; last_unit_d = mpfd_pkg::UnitVolt;
      end
      mpfd_pkg::FnDcV: begin
        pv = 1'b1; pp = rg;
        last_mode_d = mpfd_pkg::ModeDc; last_unit_d = mpfd_pkg::UnitVolt;
      end
      mpfd_pkg::FnAcV: begin
        pv = 1'b1; pp = rg;
        last_mode_d = mpfd_pkg::ModeAc; last_unit_d = mpfd_pkg::UnitVolt;
      end
      mpfd_pkg::FnDcMilliV: begin
        pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreMilli;
        last_mode_d = mpfd_pkg::ModeDc; last_unit_d = mpfd_pkg::UnitVolt;
      end
      mpfd_pkg::FnOhm: begin
        last_mode_d = mpfd_pkg::ModeOhm; last_unit_d = mpfd_pkg::UnitOhm;
        case (rg)
          4'd1: begin pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreNone; end
          4'd2: begin pv = 1'b1; pp = 4'd1; pre = mpfd_pkg::PreKilo; end
          4'd3: begin pv = 1'b1; pp = 4'd2; pre = mpfd_pkg::PreKilo; end
          4'd4: begin pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreKilo; end
          4'd5: begin pv = 1'b1; pp = 4'd1; pre = mpfd_pkg::PreMega; end
          4'd6: begin pv = 1'b1; pp = 4'd2; pre = mpfd_pkg::PreMega; end
          default: ;
        endcase
      end
      mpfd_pkg::FnCap: begin
        last_mode_d = mpfd_pkg::ModeCap; last_unit_d = mpfd_pkg::UnitFarad;
        case (rg)
          4'd1: begin pv = 1'b1; pp = 4'd2; pre = mpfd_pkg::PreNano; end
          4'd2: begin pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreNano; end
          4'd3: begin pv = 1'b1; pp = 4'd1; pre = mpfd_pkg::PreMicro; end
          4'd4: begin pv = 1'b1; pp = 4'd2; pre = mpfd_pkg::PreMicro; end
          4'd5: begin pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreMicro; end
          4'd6: begin pv = 1'b1; pp = 4'd4; pre = mpfd_pkg::PreMicro; end
          4'd7: begin pv = 1'b1; pp = 4'd2; pre = mpfd_pkg::PreMilli; end
          default: ;
        endcase
      end
      mpfd_pkg::FnTempC: begin
        pv = 1'b1; pp = 4'd4;
        last_mode_d = mpfd_pkg::ModeTemp; last_unit_d = mpfd_pkg::UnitDegC;
      end
      mpfd_pkg::FnMicroA: begin
        last_mode_d = mpfd_pkg::ac_dc_mode(pkt_i[7]);
        last_unit_d = mpfd_pkg::UnitAmp;
        pre = mpfd_pkg::PreMicro;
        if (rg == 4'd0) begin
          pv = 1'b1; pp = 4'd3;
        end else if (rg == 4'd1) begin
          pv = 1'b1; pp = 4'd4;
        end
      end
      mpfd_pkg::FnMilliA: begin
        last_mode_d = mpfd_pkg::ac_dc_mode(pkt_i[7]);
        last_unit_d = mpfd_pkg::UnitAmp;
        pre = mpfd_pkg::PreMilli;
        if (rg == 4'd0) begin
          pv = 1'b1; pp = 4'd2;
        end else if (rg == 4'd1) begin
          pv = 1'b1; pp = 4'd3;
        end
      end
      mpfd_pkg::FnAmp: begin
        last_mode_d = mpfd_pkg::ac_dc_mode(pkt_i[7]);
        last_unit_d = mpfd_pkg::UnitAmp;
        pv = 1'b1; pp = 4'd2;
      end
      mpfd_pkg::FnCont: begin
        pv = 1'b1; pp = 4'd3;
        last_mode_d = mpfd_pkg::ModeOhm; last_unit_d = mpfd_pkg::UnitOhm;
      end
      mpfd_pkg::FnDiode: begin
        pv = 1'b1; pp = 4'd1;
        last_mode_d = mpfd_pkg::ModeDiode; last_unit_d = mpfd_pkg::UnitVolt;
      end
      mpfd_pkg::FnFreq: begin
        if (pkt_i[8][mpfd_pkg::SignBit]) begin
          pv = 1'b1; pp = 4'd3;
          last_mode_d = mpfd_pkg::ModeDuty; last_unit_d = mpfd_pkg::UnitPercent;
        end else begin
          last_mode_d = mpfd_pkg::ModeFreq; last_unit_d = mpfd_pkg::UnitHertz;
          case (rg)
            4'd0: begin pv = 1'b1; pp = 4'd2; pre = mpfd_pkg::PreNone; end
            4'd1: begin pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreNone; end
            4'd2: begin pv = 1'b1; pp = 4'd1; pre = mpfd_pkg::PreKilo; end
            4'd3: begin pv = 1'b1; pp = 4'd2; pre = mpfd_pkg::PreKilo; end
            4'd4: begin pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreKilo; end
            4'd5: begin pv = 1'b1; pp = 4'd1; pre = mpfd_pkg::PreMega; end
            4'd6: begin pv = 1'b1; pp = 4'd2; pre = mpfd_pkg::PreMega; end
            4'd7: begin pv = 1'b1; pp = 4'd3; pre = mpfd_pkg::PreMega; end
            default: ;
          endcase
        end
      end
      mpfd_pkg::FnTempF: begin
        pv = 1'b1; pp = 4'd4;
        last_mode_d = mpfd_pkg::ModeTemp; last_unit_d = mpfd_pkg::UnitDegF;
      end
      default: ;
    endcase
  end

  // Mode and unit memory, updated only by a good packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_mode_q <= mpfd_pkg::ModeAc;
      last_unit_q <= mpfd_pkg::UnitVolt;
    end else if (update_i) begin
      last_mode_q <= last_mode_d;
      last_unit_q <= last_unit_d;
    end
  end

  // Assemble the result item.
  always_comb begin
    res_o.has_value      = 1'b1;
    res_o.digit_bytes    = {pkt_i[0], pkt_i[1], pkt_i[2], pkt_i[3], pkt_i[4]};
    res_o.five_digits    = (pkt_i[4] != mpfd_pkg::CharA);
    res_o.negative       = (fn != mpfd_pkg::FnFreq) && pkt_i[8][mpfd_pkg::SignBit];
    res_o.point_valid    = pv;
    res_o.point_position = pp;
    res_o.prefix_code    = pre;
    res_o.unit_code      = last_unit_d;
    res_o.mode_code      = last_mode_d;
    res_o.overflow       = (pkt_i[0] == mpfd_pkg::CharColon) &&
                           (pkt_i[1] == mpfd_pkg::CharColon) &&
                           (pkt_i[2] == mpfd_pkg::CharZero) &&
                           (pkt_i[3] == mpfd_pkg::CharLess);
    res_o.function_code  = fn;
    res_o.range_code     = rg;
  end

endmodule

// ===== tb/meter_packet_framer_decoder_test.sv =====
// Self-checking testbench for the meter packet framer and decoder.
// Predicts each decoded reading or rejected frame and compares it with the output stream.
// Depends on mpfd_pkg and meter_packet_framer_decoder.
`timescale 1ns / 100ps

module meter_packet_framer_decoder_test;
  import mpfd_pkg::*;

  // Hold-off length of the long receiver stall, and the settle time at the end.
  localparam int unsigned SinkHoldCycles = 300;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned ReportLimit    = 20;

  // The nine packet bytes ahead of CR LF, byte 0 at index 0.
  typedef logic [0:8][7:0] frame_body_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0;    // [0] port_error
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [39:0] digit_bytes, [40] five_digits, [41] negative, [42] point_valid,
  // [46:43] point_position, [49:47] prefix_code, [52:50] unit_code,
  // [56:53] mode_code, [57] overflow, [61:58] function_code, [65:62] range_code
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;           // [0] has_value

  // Predictor state: framing position, packet bytes, and the mode and unit kept.
  logic [7:0]  pkt_bytes [PacketLength];
  int unsigned byte_pos = 0;
  logic [3:0]  held_mode = ModeAc;
  logic [2:0]  held_unit = UnitVolt;

  result_t     pending_readings [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned decoded_count = 0;
  int unsigned rejected_count = 0;
  bit          steady_flow = 1'b0;
  bit          hold_sink = 1'b0;

  meter_packet_framer_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // AC, DC or AC+DC from the two low bits of the coupling byte.
  function automatic logic [3:0] coupling_mode(input logic [7:0] b);
    case (b[1:0])
      2'b01:   return ModeAc;
      2'b11:   return ModeAcDc;
      default: return ModeDc;
    endcase
  endfunction

  // Decodes a correctly framed packet and updates the kept mode and unit.
  function automatic result_t decode_reading();
    result_t    r;
    logic [3:0] fn;
    logic [3:0] rg;
    logic [3:0] mode;
    logic [2:0] unit;
    logic [7:0] pt;   // {point_valid, point_position, prefix_code}
    r    = '0;
    pt   = '0;
    fn   = pkt_bytes[6][3:0];
    rg   = pkt_bytes[5][3:0];
    mode = held_mode;
    unit = held_unit;
    case (fn)
      FnAcMilliV: begin
        mode = ModeAc; unit = UnitVolt; pt = {1'b1, 4'd3, PreMilli};
      end
      FnDcV: begin
        mode = ModeDc; unit = UnitVolt; pt = {1'b1, rg, PreNone};
      end
      FnAcV: begin
        mode = ModeAc; unit = UnitVolt; pt = {1'b1, rg, PreNone};
      end
      FnDcMilliV: begin
        mode = ModeDc; unit = UnitVolt; pt = {1'b1, 4'd3, PreMilli};
      end
      FnOhm: begin
        mode = ModeOhm;
        unit = UnitOhm;
        case (rg)
          4'd1: pt = {1'b1, 4'd3, PreNone};
          4'd2: pt = {1'b1, 4'd1, PreKilo};
          4'd3: pt = {1'b1, 4'd2, PreKilo};
          4'd4: pt = {1'b1, 4'd3, PreKilo};
          4'd5: pt = {1'b1, 4'd1, PreMega};
          4'd6: pt = {1'b1, 4'd2, PreMega};
          default: ;
        endcase
      end
      FnCap: begin
        mode = ModeCap;
        unit = UnitFarad;
        case (rg)
          4'd1: pt = {1'b1, 4'd2, PreNano};
          4'd2: pt = {1'b1, 4'd3, PreNano};
          4'd3: pt = {1'b1, 4'd1, PreMicro};
          4'd4: pt = {1'b1, 4'd2, PreMicro};
          4'd5: pt = {1'b1, 4'd3, PreMicro};
          4'd6: pt = {1'b1, 4'd4, PreMicro};
          4'd7: pt = {1'b1, 4'd2, PreMilli};
          default: ;
        endcase
      end
      FnTempC: begin
        mode = ModeTemp; unit = UnitDegC; pt = {1'b1, 4'd4, PreNone};
      end
      FnMicroA: begin
        // The prefix holds even when the range has no point position.
        mode = coupling_mode(pkt_bytes[7]);
        unit = UnitAmp;
        pt   = {1'b0, 4'd0, PreMicro};
        if (rg == 4'd0) pt = {1'b1, 4'd3, PreMicro};
        else if (rg == 4'd1) pt = {1'b1, 4'd4, PreMicro};
      end
      FnMilliA: begin
        mode = coupling_mode(pkt_bytes[7]);
        unit = UnitAmp;
        pt   = {1'b0, 4'd0, PreMilli};
        if (rg == 4'd0) pt = {1'b1, 4'd2, PreMilli};
        else if (rg == 4'd1) pt = {1'b1, 4'd3, PreMilli};
      end
      FnAmp: begin
        mode = coupling_mode(pkt_bytes[7]); unit = UnitAmp; pt = {1'b1, 4'd2, PreNone};
      end
      FnCont: begin
        mode = ModeOhm; unit = UnitOhm; pt = {1'b1, 4'd3, PreNone};
      end
      FnDiode: begin
        mode = ModeDiode; unit = UnitVolt; pt = {1'b1, 4'd1, PreNone};
      end
      FnFreq: begin
        // The sign flag selects duty cycle instead of frequency here.
        if (pkt_bytes[8][SignBit]) begin
          mode = ModeDuty; unit = UnitPercent; pt = {1'b1, 4'd3, PreNone};
        end else begin
          mode = ModeFreq;
          unit = UnitHertz;
          case (rg)
            4'd0: pt = {1'b1, 4'd2, PreNone};
            4'd1: pt = {1'b1, 4'd3, PreNone};
            4'd2: pt = {1'b1, 4'd1, PreKilo};
            4'd3: pt = {1'b1, 4'd2, PreKilo};
            4'd4: pt = {1'b1, 4'd3, PreKilo};
            4'd5: pt = {1'b1, 4'd1, PreMega};
            4'd6: pt = {1'b1, 4'd2, PreMega};
            4'd7: pt = {1'b1, 4'd3, PreMega};
            default: ;
          endcase
        end
      end
      FnTempF: begin
        mode = ModeTemp; unit = UnitDegF; pt = {1'b1, 4'd4, PreNone};
      end
      default: ;
    endcase
    held_mode = mode;
    held_unit = unit;
    r.has_value      = 1'b1;
    r.digit_bytes    = {pkt_bytes[0], pkt_bytes[1], pkt_bytes[2], pkt_bytes[3], pkt_bytes[4]};
    r.five_digits    = (pkt_bytes[4] != CharA);
    r.negative       = (fn != FnFreq) && pkt_bytes[8][SignBit];
    {r.point_valid, r.point_position, r.prefix_code} = pt;
    r.unit_code      = unit;
    r.mode_code      = mode;
    r.overflow       = (pkt_bytes[0] == CharColon) && (pkt_bytes[1] == CharColon) &&
                       (pkt_bytes[2] == CharZero) && (pkt_bytes[3] == CharLess);
    r.function_code  = fn;
    r.range_code     = rg;
    return r;
  endfunction

  // Frames one received byte; returns 1 when the byte closes or breaks a packet.
  function automatic bit frame_byte(input logic [7:0] b, input logic err,
                                    output result_t r);
    int unsigned n;
    r = '0;
    if (err) begin
      byte_pos = 0;
      return 1'b1;
    end
    pkt_bytes[byte_pos] = b;
    n = byte_pos + 1;
    if (b == CharLf) begin
      byte_pos = 0;
      if (n >= PacketLength && pkt_bytes[n-2] == CharCr) r = decode_reading();
      return 1'b1;
    end
    if (n >= PacketLength) begin
      byte_pos = 0;
      return 1'b1;
    end
    byte_pos = n;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [39:0] got_v,
                             input logic [39:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s got %0h, wanted %0h", name, got_v, want_v));
  endtask

  // Watches both handshakes at each edge: predicts on input, checks on output.
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (frame_byte(s_axis_tdata, s_axis_tuser, want)) pending_readings.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.has_value      = m_axis_tuser;
        got.digit_bytes    = m_axis_tdata[39:0];
        got.five_digits    = m_axis_tdata[40];
        got.negative       = m_axis_tdata[41];
        got.point_valid    = m_axis_tdata[42];
        got.point_position = m_axis_tdata[46:43];
        got.prefix_code    = m_axis_tdata[49:47];
        got.unit_code      = m_axis_tdata[52:50];
        got.mode_code      = m_axis_tdata[56:53];
        got.overflow       = m_axis_tdata[57];
        got.function_code  = m_axis_tdata[61:58];
        got.range_code     = m_axis_tdata[65:62];
        if (pending_readings.size() == 0) begin
          report_mismatch("result with no reading expected");
        end else begin
          want = pending_readings.pop_front();
          if (want.has_value) decoded_count++;
          else rejected_count++;
          check_field("has_value", 40'(got.has_value), 40'(want.has_value));
          check_field("digit_bytes", got.digit_bytes, want.digit_bytes);
          check_field("five_digits", 40'(got.five_digits), 40'(want.five_digits));
          check_field("negative", 40'(got.negative), 40'(want.negative));
          check_field("point_valid", 40'(got.point_valid), 40'(want.point_valid));
          check_field("point_position", 40'(got.point_position),
                      40'(want.point_position));
          check_field("prefix_code", 40'(got.prefix_code), 40'(want.prefix_code));
          check_field("unit_code", 40'(got.unit_code), 40'(want.unit_code));
          check_field("mode_code", 40'(got.mode_code), 40'(want.mode_code));
          check_field("overflow", 40'(got.overflow), 40'(want.overflow));
          check_field("function_code", 40'(got.function_code), 40'(want.function_code));
          check_field("range_code", 40'(got.range_code), 40'(want.range_code));
        end
      end
    end
  end

  // Receiver: random stall bursts, one long counted hold-off on request.
  initial begin : sink_ready
    int unsigned hold_count;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        for (hold_count = 0; hold_count < SinkHoldCycles; hold_count++) @(posedge clk_i);
        hold_sink = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one byte, sometimes after an idle burst, and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic err);
    if (!steady_flow && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= err;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_frame(input frame_body_t body);
    for (int i = 0; i < 9; i++) send_byte(body[i], 1'b0);
    send_byte(CharCr, 1'b0);
    send_byte(CharLf, 1'b0);
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic wait_for_readings();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_non_lf();
    logic [7:0] v;
    do v = 8'($urandom); while (v == CharLf);
    return v;
  endfunction

  // Random packet body with no LF; sometimes the overflow pattern or an 'A'.
  function automatic frame_body_t random_body();
    frame_body_t body;
    for (int i = 0; i < 9; i++) body[i] = random_non_lf();
    if ($urandom_range(0, 5) == 0) begin
      body[0] = CharColon;
      body[1] = CharColon;
      body[2] = CharZero;
      body[3] = CharLess;
    end
    if ($urandom_range(0, 3) == 0) body[4] = CharA;
    return body;
  endfunction

  // Good packets: duty cycle with its sign forced off, an unknown function that
  // keeps the last mode and unit with the overflow pattern and a trailing 'A',
  // a capacitance range with no table entry, and a current range with no point.
  task automatic test_good_packets();
    send_frame({8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h30, {4'h3, FnFreq}, 8'h00, 8'h04});
    send_frame({CharColon, CharColon, CharZero, CharLess, CharA, 8'hff, 8'hff, 8'hff, 8'hff});
    send_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, {4'h0, FnCap}, 8'h00, 8'h00});
    send_frame({8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h32, {4'h3, FnMicroA}, 8'h03, 8'h04});
    wait_for_readings();
  endtask

  // Broken frames: port error when idle and mid-packet, early LF, bad CR, no LF.
  task automatic test_framing_errors();
    send_byte(CharLf, 1'b1);
    send_byte(8'h31, 1'b0);
    send_byte(CharLf, 1'b0);
    for (int i = 0; i < 3; i++) send_byte(8'h30, 1'b0);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < 9; i++) send_byte(8'hff, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(CharLf, 1'b0);
    for (int i = 0; i < 9; i++) send_byte(8'h35, 1'b0);
    send_byte(CharCr, 1'b0);
    send_byte(CharCr, 1'b0);
    wait_for_readings();
  endtask

  // Mostly well-formed packets with random content, plus noise and broken frames.
  task automatic test_random_stream(input int unsigned target);
    frame_body_t body;
    int unsigned start;
    int unsigned cut;
    logic [7:0]  v;
    start = items_sent;
    while (items_sent - start < target) begin
      body = random_body();
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
        1: begin
          cut = $urandom_range(0, 8);
          for (int i = 0; i < cut; i++) send_byte(body[i], 1'b0);
          if ($urandom_range(0, 1)) send_byte(CharLf, 1'b0);
          else send_byte(8'($urandom), 1'b1);
        end
        2: begin
          for (int i = 0; i < 9; i++) send_byte(body[i], 1'b0);
          if ($urandom_range(0, 1)) begin
            do v = random_non_lf(); while (v == CharCr);
            send_byte(v, 1'b0);
            send_byte(CharLf, 1'b0);
          end else begin
            send_byte(CharCr, 1'b0);
            send_byte(random_non_lf(), 1'b0);
          end
        end
        default: send_frame(body);
      endcase
    end
    wait_for_readings();
  endtask

  // The receiver holds off while packets keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_sink = 1'b1;
    repeat (6) send_frame(random_body());
    wait_for_readings();
  endtask

  // Back-to-back packets with no idling on either side.
  task automatic test_full_rate();
    steady_flow = 1'b1;
    repeat (15) send_frame(random_body());
    wait_for_readings();
  endtask

  initial begin : run_tests
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_good_packets();
    test_framing_errors();
    test_random_stream(1350);
    test_backpressure();
    test_full_rate();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d bytes: %0d decoded packets and %0d rejected frames checked,",
             items_sent, decoded_count, rejected_count);
    $display("including a %0d-cycle receiver hold-off and a full-rate stretch.",
             SinkHoldCycles);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Slowest correct run is well under 1 ms; allow several times that.
  initial begin : watchdog
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
